// ----- design/png_chunk_walker_top_assert.svh -----
// assertion macros shared by the png chunk walker modules
// no dependencies; included by the front queue and the parser back end
`ifndef PNG_CHUNK_WALKER_TOP_ASSERT_SVH
`define PNG_CHUNK_WALKER_TOP_ASSERT_SVH

// same-cycle implication under synchronous reset
`define PCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcw assertion failed");

// next-cycle implication under synchronous reset
`define PCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcw assertion failed");

`endif

// ----- design/pcw_pkg.sv -----
// shared types, codes and constants of the png chunk walker
// no dependencies; imported by every module of the block
package pcw_pkg;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_SKIP = 3'd3,
    PH_HALT = 3'd4
  } pcw_phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_IHDR   = 2'd1;
  localparam logic [1:0] KIND_SIGERR = 2'd2;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam logic [31:0] IHDR_LEN_MIN  = 32'd13;
  localparam logic [3:0]  IHDR_BYTES    = 4'd13;
  localparam logic [3:0]  IHDR_LAST_POS = 4'd12;
  localparam logic [32:0] CRC_BYTES     = 33'd4;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } pcw_item_t;

  // queue head offered to the back end
  typedef struct packed {
    logic      valid;
    pcw_item_t item;
  } pcw_head_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'd137;
      3'd1:    v = 8'd80;
      3'd2:    v = 8'd78;
      3'd3:    v = 8'd71;
      3'd4:    v = 8'd13;
      3'd5:    v = 8'd10;
      3'd6:    v = 8'd26;
      3'd7:    v = 8'd10;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/pcw_front.sv -----
// input side: accepts bytes and holds them in a two-entry queue
// depends on pcw_pkg and the assertion macro header
`include "png_chunk_walker_top_assert.svh"

module pcw_front import pcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_data_byte,
  input  logic      in_start_of_file,
  output pcw_head_t head,
  input  logic      pop
);

  pcw_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  assign in_ready = (count_r != QUEUE_DEPTH);
  assign push     = in_valid && in_ready;

  assign head.valid = (count_r != 2'd0);
  assign head.item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{data_byte: in_data_byte, start_of_file: in_start_of_file};
    end
  end

  `PCW_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= QUEUE_DEPTH)
  `PCW_ASSERT_NOW(a_pop_nonempty, clk, rst_n, pop, count_r != 2'd0)
  `PCW_ASSERT_NEXT(a_count_track, clk, rst_n, push && !pop, count_r == $past(count_r) + 2'd1)

endmodule

// ----- design/pcw_back.sv -----
// parser back end: signature check, chunk walk, ihdr capture, output register
// depends on pcw_pkg and the assertion macro header
`include "png_chunk_walker_top_assert.svh"

module pcw_back import pcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pcw_head_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_chunk_index,
  output logic [31:0] out_chunk_length,
  output logic [31:0] out_chunk_type,
  output logic [31:0] out_image_width,
  output logic [31:0] out_image_height,
  output logic [7:0]  out_sample_depth,
  output logic [7:0]  out_pixel_format,
  output logic [7:0]  out_compression_method,
  output logic [7:0]  out_row_filter,
  output logic [7:0]  out_scan_order,
  output logic        out_is_last
);

  pcw_phase_t  phase_r, phase_nxt, ph_e;
  logic [3:0]  pos_r, pos_nxt, pos_e;
  logic [15:0] cnt_r, cnt_nxt, cnt_e;
  logic        hc_r, hc_nxt, hc_e;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [32:0] skip_r, skip_nxt, skip_dec;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] small_r, small_nxt;

  logic [7:0]  b;
  logic        sof;
  logic [31:0] len_sh, type_sh;
  logic        sig_ok, skip_done;

  logic        emit;
  logic [1:0]  r_kind;
  logic [15:0] r_index;
  logic [31:0] r_length, r_type, r_width, r_height;
  logic [7:0]  r_depth, r_color, r_comp, r_filter, r_inter;
  logic        r_last;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r;
  logic [15:0] index_r;
  logic [31:0] o_length_r, o_type_r, o_width_r, o_height_r;
  logic [7:0]  depth_r, color_r, comp_r, filter_r, inter_r;
  logic        last_r;

  assign b   = head.item.data_byte;
  assign sof = head.item.start_of_file;
  assign pop = head.valid && (!out_valid_r || out_ready);

  // start of file restarts parsing with this byte
  assign ph_e  = sof ? PH_SIG : phase_r;
  assign pos_e = sof ? 4'd0 : pos_r;
  assign cnt_e = sof ? 16'd0 : cnt_r;
  assign hc_e  = sof ? 1'b0 : hc_r;

  assign len_sh    = {len_r[23:0], b};
  assign type_sh   = {type_r[23:0], b};
  assign sig_ok    = (b == sig_byte(pos_e[2:0]));
  assign skip_dec  = (skip_r != 33'd0) ? skip_r - 33'd1 : skip_r;
  assign skip_done = (skip_dec == 33'd0);

  // next phase
  always_comb begin
    phase_nxt = ph_e;
    case (ph_e)
      PH_SIG: begin
        if (!sig_ok) phase_nxt = PH_HALT;
        else if (pos_e >= 4'd7) phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (pos_e >= 4'd3) phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        if (pos_e >= 4'd3) phase_nxt = (type_sh == TYPE_IEND) ? PH_HALT : PH_SKIP;
      end
      PH_SKIP: begin
        if (skip_done) phase_nxt = PH_LEN;
      end
      default: phase_nxt = ph_e;
    endcase
  end

  // result of this byte
  always_comb begin
    emit     = 1'b0;
    r_kind   = KIND_HEADER;
    r_index  = cnt_e;
    r_length = len_r;
    r_type   = type_r;
    r_width  = 32'd0;
    r_height = 32'd0;
    r_depth  = 8'd0;
    r_color  = 8'd0;
    r_comp   = 8'd0;
    r_filter = 8'd0;
    r_inter  = 8'd0;
    r_last   = 1'b0;
    case (ph_e)
      PH_SIG: begin
        if (!sig_ok) begin
          emit     = 1'b1;
          r_kind   = KIND_SIGERR;
          r_index  = 16'd0;
          r_length = 32'd0;
          r_type   = 32'd0;
          r_last   = 1'b1;
        end
      end
      PH_TYPE: begin
        if (pos_e >= 4'd3) begin
          emit   = 1'b1;
          r_type = type_sh;
          r_last = (type_sh == TYPE_IEND);
        end
      end
      PH_SKIP: begin
        if (hc_e && pos_e == IHDR_LAST_POS) begin
          emit     = 1'b1;
          r_kind   = KIND_IHDR;
          r_width  = width_r;
          r_height = height_r;
          r_depth  = small_r[31:24];
          r_color  = small_r[23:16];
          r_comp   = small_r[15:8];
          r_filter = small_r[7:0];
          r_inter  = b;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    pos_nxt    = pos_e;
    cnt_nxt    = cnt_e;
    hc_nxt     = hc_e;
    len_nxt    = len_r;
    type_nxt   = type_r;
    skip_nxt   = skip_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    small_nxt  = small_r;
    case (ph_e)
      PH_SIG: begin
        if (sig_ok) pos_nxt = (pos_e >= 4'd7) ? 4'd0 : pos_e + 4'd1;
      end
      PH_LEN: begin
        len_nxt = len_sh;
        pos_nxt = (pos_e >= 4'd3) ? 4'd0 : pos_e + 4'd1;
      end
      PH_TYPE: begin
        type_nxt = type_sh;
        if (pos_e < 4'd3) begin
          pos_nxt = pos_e + 4'd1;
        end else begin
          pos_nxt  = 4'd0;
          hc_nxt   = (type_sh == TYPE_IHDR) && (len_r >= IHDR_LEN_MIN);
          skip_nxt = {1'b0, len_r} + CRC_BYTES;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (hc_e && pos_e < IHDR_BYTES) begin
          if (pos_e < 4'd4) width_nxt = {width_r[23:0], b};
          else if (pos_e < 4'd8) height_nxt = {height_r[23:0], b};
          else if (pos_e < IHDR_LAST_POS) small_nxt = {small_r[23:0], b};
          if (pos_e == IHDR_LAST_POS) hc_nxt = 1'b0;
          pos_nxt = pos_e + 4'd1;
        end
        if (skip_done) begin
          pos_nxt = 4'd0;
          hc_nxt  = 1'b0;
          if (cnt_e != COUNT_MAX) cnt_nxt = cnt_e + 16'd1;
        end
      end
      default: pos_nxt = pos_e;
    endcase
  end

  always_comb begin
    if (pop && emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG;
      pos_r       <= 4'd0;
      cnt_r       <= 16'd0;
      hc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        cnt_r   <= cnt_nxt;
        hc_r    <= hc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      skip_r   <= skip_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      small_r  <= small_nxt;
    end
    if (pop && emit) begin
      kind_r     <= r_kind;
      index_r    <= r_index;
      o_length_r <= r_length;
      o_type_r   <= r_type;
      o_width_r  <= r_width;
      o_height_r <= r_height;
      depth_r    <= r_depth;
      color_r    <= r_color;
      comp_r     <= r_comp;
      filter_r   <= r_filter;
      inter_r    <= r_inter;
      last_r     <= r_last;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_kind               = kind_r;
  assign out_chunk_index        = index_r;
  assign out_chunk_length       = o_length_r;
  assign out_chunk_type         = o_type_r;
  assign out_image_width        = o_width_r;
  assign out_image_height       = o_height_r;
  assign out_sample_depth       = depth_r;
  assign out_pixel_format       = color_r;
  assign out_compression_method = comp_r;
  assign out_row_filter         = filter_r;
  assign out_scan_order         = inter_r;
  assign out_is_last            = last_r;

  `PCW_ASSERT_NOW(a_sigerr_last, clk, rst_n, out_valid_r && kind_r == KIND_SIGERR, last_r)
  `PCW_ASSERT_NOW(a_capture_in_skip, clk, rst_n, hc_r, phase_r == PH_SKIP)
  `PCW_ASSERT_NEXT(a_halt_silent, clk, rst_n,
                   pop && phase_r == PH_HALT && !sof && out_ready, !out_valid_r)

endmodule

// ----- design/png_chunk_walker_top.sv -----
// top level of the png chunk walker: front queue feeding the parser back end
// depends on pcw_pkg, pcw_front and pcw_back
//
// The block parses a PNG file fed one byte per item and sustains one byte per
// clock while the receiver does not stall: a two-entry queue in the front takes
// a byte in every cycle that it has room, and the parser in the back consumes
// one byte a cycle whenever its output register is empty or is being drained.
// A byte that causes a result passes through a queue slot and then the output
// register before the result is offered. Assert start_of_file on the first
// signature byte of each file; after a signature error or the IEND header the
// parser ignores bytes until the next start of file.

module png_chunk_walker_top import pcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_chunk_index,
  output logic [31:0] out_chunk_length,
  output logic [31:0] out_chunk_type,
  output logic [31:0] out_image_width,
  output logic [31:0] out_image_height,
  output logic [7:0]  out_sample_depth,
  output logic [7:0]  out_pixel_format,
  output logic [7:0]  out_compression_method,
  output logic [7:0]  out_row_filter,
  output logic [7:0]  out_scan_order,
  output logic        out_is_last
);

  pcw_head_t head;
  logic      pop;

  pcw_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_start_of_file (in_start_of_file),
    .head             (head),
    .pop              (pop)
  );

  pcw_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head                   (head),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_kind               (out_kind),
    .out_chunk_index        (out_chunk_index),
    .out_chunk_length       (out_chunk_length),
    .out_chunk_type         (out_chunk_type),
    .out_image_width        (out_image_width),
    .out_image_height       (out_image_height),
    .out_sample_depth       (out_sample_depth),
    .out_pixel_format       (out_pixel_format),
    .out_compression_method (out_compression_method),
    .out_row_filter         (out_row_filter),
    .out_scan_order         (out_scan_order),
    .out_is_last            (out_is_last)
  );

endmodule

// ----- tb/tb_top.sv -----
// self-checking bench for png_chunk_walker_top: feeds PNG byte streams and
// checks every chunk report against a byte-level walker kept in the bench
// depends on pcw_pkg and the png_chunk_walker_top RTL
module tb_top;
  import pcw_pkg::*;

  localparam logic [63:0] PNG_MAGIC      = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] TYPE_IDAT      = 32'h4944_4154;
  localparam int          WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] index;
    logic [31:0] len;
    logic [31:0] ctype;
    logic [31:0] width;
    logic [31:0] height;
    logic [7:0]  depth;
    logic [7:0]  color;
    logic [7:0]  compress;
    logic [7:0]  filter;
    logic [7:0]  interlace;
    logic        last;
  } chunk_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_start_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_chunk_index;
  logic [31:0] out_chunk_length;
  logic [31:0] out_chunk_type;
  logic [31:0] out_image_width;
  logic [31:0] out_image_height;
  logic [7:0]  out_sample_depth;
  logic [7:0]  out_pixel_format;
  logic [7:0]  out_compression_method;
  logic [7:0]  out_row_filter;
  logic [7:0]  out_scan_order;
  logic        out_is_last;

  // walker state mirrored in the bench
  pcw_phase_t  ph;
  logic [3:0]  pos;
  logic [31:0] len_acc;
  logic [31:0] type_acc;
  logic [32:0] skip_left;
  logic [15:0] chunk_num;
  logic        capture;
  logic [31:0] wid_acc;
  logic [31:0] hgt_acc;
  logic [31:0] small_acc;

  chunk_report_t pending_chunk_reports[$];
  chunk_report_t want_report;

  bit idle_on = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int failures = 0;
  int bytes_sent = 0;
  int reports_checked = 0;
  int files_started = 0;

  always #4 clk = ~clk;

  png_chunk_walker_top i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_start_of_file       (in_start_of_file),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_kind               (out_kind),
    .out_chunk_index        (out_chunk_index),
    .out_chunk_length       (out_chunk_length),
    .out_chunk_type         (out_chunk_type),
    .out_image_width        (out_image_width),
    .out_image_height       (out_image_height),
    .out_sample_depth       (out_sample_depth),
    .out_pixel_format       (out_pixel_format),
    .out_compression_method (out_compression_method),
    .out_row_filter         (out_row_filter),
    .out_scan_order         (out_scan_order),
    .out_is_last            (out_is_last)
  );

  function automatic logic [7:0] magic_byte(input int i);
    return PNG_MAGIC[63 - 8 * i -: 8];
  endfunction

  task automatic clear_walker();
    ph = PH_SIG;
    pos = '0;
    len_acc = '0;
    type_acc = '0;
    skip_left = '0;
    chunk_num = '0;
    capture = 1'b0;
    wid_acc = '0;
    hgt_acc = '0;
    small_acc = '0;
  endtask

  // advance the walker by one accepted byte and queue the report it causes
  task automatic walk_png_byte(input logic [7:0] b, input logic sof);
    chunk_report_t r;
    r = '0;
    if (sof) clear_walker();
    case (ph)
      PH_SIG: begin
        if (b != magic_byte(int'(pos[2:0]))) begin
          r.kind = KIND_SIGERR;
          r.last = 1'b1;
          ph = PH_HALT;
          pending_chunk_reports.push_back(r);
        end else if (pos >= 4'd7) begin
          ph = PH_LEN;
          pos = '0;
        end else begin
          pos++;
        end
      end
      PH_LEN: begin
        len_acc = {len_acc[23:0], b};
        if (pos >= 4'd3) begin
          ph = PH_TYPE;
          pos = '0;
        end else begin
          pos++;
        end
      end
      PH_TYPE: begin
        type_acc = {type_acc[23:0], b};
        if (pos < 4'd3) begin
          pos++;
        end else begin
          pos = '0;
          r.kind = KIND_HEADER;
          r.index = chunk_num;
          r.len = len_acc;
          r.ctype = type_acc;
          if (type_acc == TYPE_IEND) begin
            r.last = 1'b1;
            ph = PH_HALT;
          end else begin
            capture = (type_acc == TYPE_IHDR) && (len_acc >= IHDR_LEN_MIN);
            skip_left = {1'b0, len_acc} + CRC_BYTES;
            ph = PH_SKIP;
          end
          pending_chunk_reports.push_back(r);
        end
      end
      PH_SKIP: begin
        if (capture && pos < IHDR_BYTES) begin
          if (pos < 4'd4) wid_acc = {wid_acc[23:0], b};
          else if (pos < 4'd8) hgt_acc = {hgt_acc[23:0], b};
          else if (pos < 4'd12) small_acc = {small_acc[23:0], b};
          if (pos == IHDR_LAST_POS) begin
            r.kind = KIND_IHDR;
            r.index = chunk_num;
            r.len = len_acc;
            r.ctype = type_acc;
            r.width = wid_acc;
            r.height = hgt_acc;
            {r.depth, r.color, r.compress, r.filter} = small_acc;
            r.interlace = b;
            capture = 1'b0;
            pending_chunk_reports.push_back(r);
          end
          pos++;
        end
        if (skip_left != '0) skip_left--;
        if (skip_left == '0) begin
          ph = PH_LEN;
          pos = '0;
          capture = 1'b0;
          if (chunk_num != COUNT_MAX) chunk_num++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // result check first, then the predictor; watchdog on quiet cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        reports_checked++;
        if (pending_chunk_reports.size() == 0) begin
          $error("unexpected result: kind %0d index %0d", out_kind, out_chunk_index);
          failures++;
        end else begin
          want_report = pending_chunk_reports.pop_front();
          check_field("kind", 32'(want_report.kind), 32'(out_kind));
          check_field("chunk_index", 32'(want_report.index), 32'(out_chunk_index));
          check_field("chunk_length", want_report.len, out_chunk_length);
          check_field("chunk_type", want_report.ctype, out_chunk_type);
          check_field("image_width", want_report.width, out_image_width);
          check_field("image_height", want_report.height, out_image_height);
          check_field("sample_depth", 32'(want_report.depth), 32'(out_sample_depth));
          check_field("pixel_format", 32'(want_report.color), 32'(out_pixel_format));
          check_field("compression_method", 32'(want_report.compress),
                      32'(out_compression_method));
          check_field("row_filter", 32'(want_report.filter), 32'(out_row_filter));
          check_field("scan_order", 32'(want_report.interlace), 32'(out_scan_order));
          check_field("is_last", 32'(want_report.last), 32'(out_is_last));
        end
      end
      if (in_valid && in_ready) walk_png_byte(in_data_byte, in_start_of_file);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
    out_ready <= (stall_left == 0);
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_of_file <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_magic(input int upto);
    if (upto > 0) files_started++;
    for (int i = 0; i < upto; i++) send_byte(magic_byte(i), i == 0);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[31 - 8 * i -: 8], 1'b0);
  endtask

  task automatic send_fill(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // header, random data and crc bytes
  task automatic send_chunk(input logic [31:0] len, input logic [31:0] ctype);
    send_word(len);
    send_word(ctype);
    send_fill(int'(len) + 4);
  endtask

  task automatic test_signature_errors();
    idle_on = 1'b1;
    files_started++;
    send_byte(magic_byte(0) ^ 8'h01, 1'b1);
    send_fill(2);
    send_magic(7);
    send_byte(magic_byte(7) ^ 8'h80, 1'b0);
    send_fill(2);
  endtask

  task automatic test_ihdr_extremes();
    send_magic(8);
    send_word(32'd13);
    send_word(TYPE_IHDR);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'hFF00_FF00);
    send_byte(8'hFF, 1'b0);
    send_fill(4);
    // short ihdr gives a header only
    send_word(32'd12);
    send_word(TYPE_IHDR);
    send_fill(16);
    send_chunk(32'd0, TYPE_IDAT);
    send_word(32'd0);
    send_word(TYPE_IEND);
    send_fill(3);
  endtask

  task automatic test_restart_mid_chunk();
    send_magic(8);
    send_word(32'hFFFF_FFFF);
    send_word(TYPE_IHDR);
    send_fill(20);
    send_magic(8);
    send_word(32'hFFFF_FFFF);
    send_word(TYPE_IEND);
  endtask

  task automatic test_random_files();
    int target;
    int k;
    logic [31:0] len;
    logic [31:0] ctype;
    target = bytes_sent + 550;
    while (bytes_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 15))
        0: repeat ($urandom_range(1, 6))
             send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        1: begin
          k = $urandom_range(0, 7);
          if (k == 0) files_started++;
          send_magic(k);
          send_byte(magic_byte(k) ^ 8'($urandom_range(1, 255)), k == 0);
          send_fill($urandom_range(0, 2));
        end
        default: begin
          send_magic(8);
          case ($urandom_range(0, 5))
            0:       len = $urandom_range(0, 12);
            1:       len = $urandom_range(14, 24);
            default: len = 32'd13;
          endcase
          ctype = ($urandom_range(0, 7) == 0) ? $urandom : TYPE_IHDR;
          send_chunk(len, ctype);
          repeat ($urandom_range(0, 4)) begin
            ctype = ($urandom_range(0, 5) == 0) ? TYPE_IHDR : $urandom;
            if (ctype == TYPE_IEND) ctype[0] = ~ctype[0];
            len = ($urandom_range(0, 5) == 0) ? 32'd13 : $urandom_range(0, 24);
            send_chunk(len, ctype);
          end
          // some files are cut off and the next start of file takes over
          if ($urandom_range(0, 5) == 0) begin
            send_fill($urandom_range(1, 11));
          end else begin
            send_word($urandom);
            send_word(TYPE_IEND);
            send_fill($urandom_range(0, 3));
          end
        end
      endcase
    end
  endtask

  // one file with no idling on either side so bytes and results run back to back
  task automatic test_back_to_back();
    logic [31:0] ctype;
    idle_on = 1'b0;
    send_magic(8);
    send_word(32'd13);
    send_word(TYPE_IHDR);
    send_fill(17);
    repeat (6) begin
      ctype = $urandom;
      if (ctype == TYPE_IEND) ctype[0] = ~ctype[0];
      send_chunk(32'($urandom_range(0, 3)), ctype);
    end
    send_word(32'd0);
    send_word(TYPE_IEND);
  endtask

  initial begin
    clear_walker();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_signature_errors();
    test_ihdr_extremes();
    test_restart_mid_chunk();
    test_random_files();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_chunk_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("sent %0d bytes over %0d files, checked %0d chunk reports", bytes_sent,
             files_started, reports_checked);
    $display("covered signature errors, ihdr capture, short ihdr, restarts and full-rate streams");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
